// File: src/xsfs_pkg.sv
// shared types and codes of the xor sprite frame store
`default_nettype none
package xsfs_pkg;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned DEPTH = 512;
  localparam int unsigned ADDR_W = 9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [2:0] OP_DRAW   = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_DOWN   = 3'd2;
  localparam logic [2:0] OP_UP     = 3'd3;
  localparam logic [2:0] OP_LEFT   = 3'd4;
  localparam logic [2:0] OP_RIGHT  = 3'd5;
  localparam logic [2:0] OP_MODE   = 3'd6;
  localparam logic [2:0] OP_READ   = 3'd7;

  localparam logic [2:0] SW_CLEAR  = 3'd0;
  localparam logic [2:0] SW_DOWN   = 3'd1;
  localparam logic [2:0] SW_UP     = 3'd2;
  localparam logic [2:0] SW_LEFT   = 3'd3;
  localparam logic [2:0] SW_RIGHT  = 3'd4;

  localparam logic [0:0] REG_WRAP_X    = 1'b0;
  localparam logic [0:0] REG_COUNT_OVF = 1'b1;

  localparam logic [4:0] HIT_LIMIT = 5'd16;
endpackage
`default_nettype wire

// File: src/xsfs_ram.sv
// generic single write, single read ram with registered read
`default_nettype none
module xsfs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/xsfs_lane.sv
// one draw lane: xor of a sprite slice into a store word and erase detection
`default_nettype none
module xsfs_lane (
  input  wire xsfs_pkg::word_t old_word,
  input  wire xsfs_pkg::word_t mask,
  output xsfs_pkg::word_t      new_word,
  output logic                 hit
);
  assign new_word = old_word ^ mask;
  assign hit      = |(old_word & mask);
endmodule
`default_nettype wire

// File: src/xor_sprite_frame_store_top.sv
// top level of the xor sprite frame store
//
// one-bit frame store, 128x64 or 64x32 cells, kept as 512 words of 16 cells
// in one ram, word address = row * words_per_row + column / 16, msb leftmost
// input: a transaction is taken when start is high and busy is low; fields
// are sampled at that edge. one operation is worked on at a time
// result: exactly one per transaction, shown for one cycle with out_valid;
// the receiver cannot stall, so results are never held back
// config: cfg_valid/cfg_ready write port, always ready, index 0 wrap_x,
// index 1 count_overflow_rows, other indexes ignored
// steps from accept to out_valid:
//   draw row: two ram reads, two lanes, two writes, merge
//   read: two ram reads; mode switch or zero vertical scroll: no ram access
//   clear sweeps the whole ram, scrolls sweep words_per_screen words
//   mode switch low to high clears the upper area
// every sweep moves one ram word per cycle through the single write port
// reset: synchronous active low; afterwards a clearing pass over the whole
// ram zeroes it while busy stays high; config writes are taken meanwhile
`default_nettype none
module xor_sprite_frame_store_top #(
  parameter int unsigned SCROLL_SIDE_STEP = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic [7:0]  in_pos_x,
  input  wire logic [7:0]  in_pos_y,
  input  wire logic [3:0]  in_sprite_row,
  input  wire logic [15:0] in_sprite_bits,
  input  wire logic        in_wide,
  input  wire logic        in_last_row,
  input  wire logic [3:0]  in_scroll_count,
  input  wire logic        in_high_res_select,
  output logic             out_valid,
  output logic [15:0]      out_read_pixels,
  output logic             out_row_hit,
  output logic [4:0]       out_hit_rows,
  output logic             out_draw_done,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_RD0   = 3'd2;
  localparam logic [2:0] ST_RD1   = 3'd3;
  localparam logic [2:0] ST_RD2   = 3'd4;
  localparam logic [2:0] ST_RD3   = 3'd5;
  localparam logic [2:0] ST_SWEEP = 3'd6;

  localparam int unsigned WW = xsfs_pkg::WORD_W;

  logic [2:0]  state_r;
  logic [2:0]  op_r;
  logic [7:0]  x_r;
  logic [8:0]  y_r;
  logic [15:0] bits_r;
  logic        last_r, srow0_r, sel_r;
  logic [3:0]  scount_r;
  logic        hr_r, wrap_r, cov_r;
  logic [4:0]  hit_cnt_r;
  xsfs_pkg::word_t worda_r, newb_r, prev_r;
  logic        hitab_r;
  logic [2:0]  sw_op_r;
  xsfs_pkg::addr_t idx_r, paddr_r;
  logic [9:0]  cnt_r;
  logic        sw_report_r, pv_r, pzero_r, pbound_r;
  logic        out_valid_r, out_row_hit_r, out_draw_done_r;
  logic [15:0] out_read_pixels_r;
  logic [4:0]  out_hit_rows_r;

  // ram ports
  logic            ram_we;
  xsfs_pkg::addr_t ram_waddr, ram_raddr;
  xsfs_pkg::word_t ram_wdata, rd_data;

  xsfs_ram #(.WIDTH(WW), .DEPTH(xsfs_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // geometry of the current mode
  logic [6:0] s_col;
  logic [2:0] wa, wb, wpr_m1;
  logic [3:0] offs;
  logic       x_in, y_in, b_edge;
  xsfs_pkg::addr_t row_base, addr_a, addr_b;
  logic [31:0] win, rd_win;
  xsfs_pkg::word_t mask_a, mask_b, new_a, new_b;
  logic        hit_a, hit_b, skip_all, ovf_hit;

  assign s_col    = hr_r ? x_r[6:0] : {1'b0, x_r[5:0]};
  assign wa       = s_col[6:4];
  assign offs     = s_col[3:0];
  assign wpr_m1   = hr_r ? 3'd7 : 3'd3;
  assign wb       = (wa + 3'd1) & wpr_m1;
  assign b_edge   = (wa == wpr_m1);
  assign x_in     = !x_r[7] && (hr_r || !x_r[6]);
  assign y_in     = hr_r ? (y_r < 9'd64) : (y_r < 9'd32);
  assign row_base = hr_r ? {y_r[5:0], 3'b000} : {2'b00, y_r[4:0], 2'b00};
  assign addr_a   = row_base | {6'd0, wa};
  assign addr_b   = row_base | {6'd0, wb};

  // sprite placed across the two words it can touch
  assign win      = {bits_r, 16'h0000} >> offs;
  assign skip_all = !y_in || (!wrap_r && !x_in);
  assign mask_a   = skip_all ? '0 : win[31:16];
  assign mask_b   = (skip_all || (!wrap_r && b_edge)) ? '0 : win[15:0];
  assign ovf_hit  = !y_in && cov_r && (wrap_r || x_in);

  // two lanes, one per touched word
  xsfs_lane u_lane_a (.old_word(worda_r), .mask(mask_a), .new_word(new_a), .hit(hit_a));
  xsfs_lane u_lane_b (.old_word(rd_data), .mask(mask_b), .new_word(new_b), .hit(hit_b));

  // read window, no wrap, off-screen as zero
  xsfs_pkg::word_t rda, rdb;
  assign rda    = (x_in && y_in) ? worda_r : '0;
  assign rdb    = (x_in && y_in && !b_edge) ? rd_data : '0;
  assign rd_win = {rda, rdb} << offs;

  // merge of lane hits and hit row count
  logic       row_hit;
  logic [4:0] cnt_base, cnt_new;
  assign row_hit  = hitab_r || ovf_hit;
  assign cnt_base = srow0_r ? 5'd0 : hit_cnt_r;
  assign cnt_new  = (row_hit && cnt_base < xsfs_pkg::HIT_LIMIT) ? cnt_base + 5'd1 : cnt_base;

  // sweep address generation
  logic [6:0] kv;
  logic [9:0] n_words;
  xsfs_pkg::addr_t src_addr, idx_next;
  logic       src_zero, bound, sw_desc, issue;
  assign kv      = hr_r ? {scount_r, 3'b000} : {1'b0, scount_r, 2'b00};
  assign n_words = hr_r ? 10'd512 : 10'd128;
  assign sw_desc = (sw_op_r == xsfs_pkg::SW_DOWN) || (sw_op_r == xsfs_pkg::SW_LEFT);
  assign issue   = (state_r == ST_SWEEP) && (cnt_r != 10'd0);
  assign idx_next = sw_desc ? idx_r - 9'd1 : idx_r + 9'd1;

  always_comb begin
    src_addr = idx_r;
    src_zero = 1'b0;
    bound    = 1'b0;
    case (sw_op_r)
      xsfs_pkg::SW_CLEAR: src_zero = 1'b1;
      xsfs_pkg::SW_DOWN: begin
        src_addr = idx_r - {2'b00, kv};
        src_zero = idx_r < {2'b00, kv};
      end
      xsfs_pkg::SW_UP: begin
        src_addr = idx_r + {2'b00, kv};
        src_zero = {1'b0, idx_r} >= (n_words - {3'b000, kv});
      end
      xsfs_pkg::SW_LEFT:  bound = (idx_r[2:0] & wpr_m1) == wpr_m1;
      xsfs_pkg::SW_RIGHT: bound = (idx_r[2:0] & wpr_m1) == 3'd0;
      default: src_zero = 1'b1;
    endcase
  end

  // write data of a sweep step
  xsfs_pkg::word_t sw_wdata;
  always_comb begin
    case (sw_op_r)
      xsfs_pkg::SW_LEFT:
        sw_wdata = (rd_data << SCROLL_SIDE_STEP) |
                   (pbound_r ? '0 : (prev_r >> (WW - SCROLL_SIDE_STEP)));
      xsfs_pkg::SW_RIGHT:
        sw_wdata = (rd_data >> SCROLL_SIDE_STEP) |
                   (pbound_r ? '0 : (prev_r << (WW - SCROLL_SIDE_STEP)));
      default: sw_wdata = pzero_r ? '0 : rd_data;
    endcase
  end

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_a;
    ram_wdata = new_a;
    ram_raddr = addr_a;
    case (state_r)
      ST_RD1: ram_raddr = addr_b;
      ST_RD2: ram_we = (op_r == xsfs_pkg::OP_DRAW) && y_in;
      ST_RD3: begin
        ram_we    = (op_r == xsfs_pkg::OP_DRAW) && y_in;
        ram_waddr = addr_b;
        ram_wdata = newb_r;
      end
      ST_SWEEP: begin
        ram_raddr = src_addr;
        ram_we    = pv_r;
        ram_waddr = paddr_r;
        ram_wdata = sw_wdata;
      end
      default: ram_raddr = addr_a;
    endcase
  end

  // config port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= 1'b1;
      cov_r  <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == {1'b0, xsfs_pkg::REG_WRAP_X}) wrap_r <= cfg_data;
      if (cfg_index == {1'b0, xsfs_pkg::REG_COUNT_OVF}) cov_r <= cfg_data;
    end
  end

  // payload of the accepted transaction
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r     <= in_operation;
      x_r      <= in_pos_x;
      // sprite row offsets only a draw; a read uses the row as given
      y_r      <= {1'b0, in_pos_y} +
                  ((in_operation == xsfs_pkg::OP_DRAW) ? {5'd0, in_sprite_row} : 9'd0);
      bits_r   <= in_wide ? in_sprite_bits : {in_sprite_bits[15:8], 8'h00};
      last_r   <= in_last_row;
      srow0_r  <= (in_sprite_row == 4'd0);
      scount_r <= in_scroll_count;
      sel_r    <= in_high_res_select;
    end
    if (state_r == ST_RD1) worda_r <= rd_data;
    if (state_r == ST_RD2) begin
      newb_r  <= new_b;
      hitab_r <= hit_a || hit_b;
    end
    if (pv_r) prev_r <= rd_data;
    paddr_r  <= idx_r;
    pzero_r  <= src_zero;
    pbound_r <= bound;
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sw_op_r     <= xsfs_pkg::SW_CLEAR;
      idx_r       <= '0;
      cnt_r       <= 10'd512;
      sw_report_r <= 1'b0;
      pv_r        <= 1'b0;
      hr_r        <= 1'b0;
      hit_cnt_r   <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r       <= 1'b0;
      out_read_pixels_r <= '0;
      out_row_hit_r     <= 1'b0;
      out_hit_rows_r    <= '0;
      out_draw_done_r   <= 1'b0;
      pv_r              <= issue;
      case (state_r)
        ST_IDLE: if (start) state_r <= ST_EXEC;
        ST_EXEC: begin
          sw_report_r <= 1'b1;
          case (op_r)
            xsfs_pkg::OP_DRAW, xsfs_pkg::OP_READ: state_r <= ST_RD0;
            xsfs_pkg::OP_CLEAR: begin
              state_r <= ST_SWEEP;
              sw_op_r <= xsfs_pkg::SW_CLEAR;
              idx_r   <= '0;
              cnt_r   <= 10'd512;
            end
            xsfs_pkg::OP_DOWN, xsfs_pkg::OP_UP: begin
              if (scount_r == 4'd0) begin
                state_r     <= ST_IDLE;
                out_valid_r <= 1'b1;
              end else begin
                state_r <= ST_SWEEP;
                sw_op_r <= (op_r == xsfs_pkg::OP_DOWN) ? xsfs_pkg::SW_DOWN : xsfs_pkg::SW_UP;
                idx_r   <= (op_r == xsfs_pkg::OP_DOWN) ? n_words[8:0] - 9'd1 : 9'd0;
                cnt_r   <= n_words;
              end
            end
            xsfs_pkg::OP_LEFT, xsfs_pkg::OP_RIGHT: begin
              state_r <= ST_SWEEP;
              sw_op_r <= (op_r == xsfs_pkg::OP_LEFT) ? xsfs_pkg::SW_LEFT : xsfs_pkg::SW_RIGHT;
              idx_r   <= (op_r == xsfs_pkg::OP_LEFT) ? n_words[8:0] - 9'd1 : 9'd0;
              cnt_r   <= n_words;
            end
            default: begin
              // mode switch; low to high clears words past the low area
              hr_r <= sel_r;
              if (sel_r && !hr_r) begin
                state_r <= ST_SWEEP;
                sw_op_r <= xsfs_pkg::SW_CLEAR;
                idx_r   <= 9'd128;
                cnt_r   <= 10'd384;
              end else begin
                state_r     <= ST_IDLE;
                out_valid_r <= 1'b1;
              end
            end
          endcase
        end
        ST_RD0: state_r <= ST_RD1;
        ST_RD1: state_r <= ST_RD2;
        ST_RD2: begin
          if (op_r == xsfs_pkg::OP_READ) begin
            state_r           <= ST_IDLE;
            out_valid_r       <= 1'b1;
            out_read_pixels_r <= rd_win[31:16];
          end else begin
            state_r <= ST_RD3;
          end
        end
        ST_RD3: begin
          state_r         <= ST_IDLE;
          hit_cnt_r       <= cnt_new;
          out_valid_r     <= 1'b1;
          out_row_hit_r   <= row_hit;
          out_hit_rows_r  <= cnt_new;
          out_draw_done_r <= last_r;
        end
        ST_SWEEP: begin
          if (issue) begin
            idx_r <= idx_next;
            cnt_r <= cnt_r - 10'd1;
          end else if (!pv_r) begin
            state_r     <= ST_IDLE;
            out_valid_r <= sw_report_r;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_pixels = out_read_pixels_r;
  assign out_row_hit     = out_row_hit_r;
  assign out_hit_rows    = out_hit_rows_r;
  assign out_draw_done   = out_draw_done_r;
endmodule
`default_nettype wire

// File: src/xsfs_checker.sv
// port level checks of the xor sprite frame store and their binding
`default_nettype none
module xsfs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic       out_row_hit,
  input wire logic [4:0] out_hit_rows,
  input wire logic       out_draw_done
);
  // clearing pass runs after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy && !out_valid)
    else $error("no clearing pass after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_hit |-> out_hit_rows != 5'd0 && out_hit_rows <= 5'd16)
    else $error("hit row count out of range");

  a_done_only_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_draw_done |-> out_valid)
    else $error("draw done without result");
endmodule

bind xor_sprite_frame_store_top xsfs_checker u_xsfs_checker (.*);
`default_nettype wire
